// ----- rtl/arm_pkg.sv -----
package arm_pkg;

  // request and result fields
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned RIGHT_W   = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ENTRY_W   = 9;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // most results one list request may give
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CW      = $clog2(MAX_RESULTS);

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_REG   = 3'd3;
  localparam logic [OP_W-1:0] OP_DSUB  = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBJECTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS  = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET    = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [ID_W-1:0]    subject;
    logic [ID_W-1:0]    object;
    logic [RIGHT_W-1:0] right_index;
    logic [MASK_W-1:0]  rights_mask;
  } arm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     subject_id;
    logic                last;
    logic [ENTRY_W-1:0]  entry_count;
  } arm_res_t;

  // microcode fields
  typedef logic [3:0] upc_t;

  typedef enum logic [1:0] {
    ASEL_CELL,
    ASEL_ROW,
    ASEL_COL
  } asel_e;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_CELL,
    ACT_EMIT,
    ACT_REG,
    ACT_CLR,
    ACT_DSDONE,
    ACT_LIST,
    ACT_LEND
  } act_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_REG_STOP,
    C_DS_REFUSE,
    C_ROW_DONE,
    C_OBJ_BAD,
    C_LIST_STOP
  } cond_e;

  typedef struct packed {
    asel_e asel;
    logic  rd;
    act_e  act;
    cond_e cond;
    logic  hold;
    logic  fin;
    upc_t  jmp;
  } uword_t;

  // microprogram addresses
  localparam upc_t UA_CELL_RD = 4'd0;
  localparam upc_t UA_CELL_EX = 4'd1;
  localparam upc_t UA_EMIT    = 4'd2;
  localparam upc_t UA_REG     = 4'd3;
  localparam upc_t UA_DS_CHK  = 4'd4;
  localparam upc_t UA_DS_CLR  = 4'd5;
  localparam upc_t UA_DS_END  = 4'd6;
  localparam upc_t UA_LS_CHK  = 4'd7;
  localparam upc_t UA_LS_SCAN = 4'd8;
  localparam upc_t UA_LS_END  = 4'd9;

  function automatic uword_t uw(input asel_e asel, input logic rd, input act_e act,
                                input cond_e cond, input logic hold, input logic fin,
                                input upc_t jmp);
    uword_t w;
    w.asel = asel;
    w.rd   = rd;
    w.act  = act;
    w.cond = cond;
    w.hold = hold;
    w.fin  = fin;
    w.jmp  = jmp;
    return w;
  endfunction

  // control store: one word per step
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      UA_CELL_RD: w = uw(ASEL_CELL, 1'b1, ACT_NOP,    C_NONE,      1'b0, 1'b0, UA_CELL_RD);
      UA_CELL_EX: w = uw(ASEL_CELL, 1'b0, ACT_CELL,   C_NONE,      1'b0, 1'b0, UA_CELL_RD);
      UA_EMIT:    w = uw(ASEL_CELL, 1'b0, ACT_EMIT,   C_NONE,      1'b0, 1'b1, UA_CELL_RD);
      UA_REG:     w = uw(ASEL_CELL, 1'b0, ACT_REG,    C_REG_STOP,  1'b1, 1'b0, UA_EMIT);
      UA_DS_CHK:  w = uw(ASEL_CELL, 1'b0, ACT_NOP,    C_DS_REFUSE, 1'b0, 1'b0, UA_EMIT);
      UA_DS_CLR:  w = uw(ASEL_ROW,  1'b1, ACT_CLR,    C_ROW_DONE,  1'b1, 1'b0, UA_DS_END);
      UA_DS_END:  w = uw(ASEL_CELL, 1'b0, ACT_DSDONE, C_ALWAYS,    1'b0, 1'b0, UA_EMIT);
      UA_LS_CHK:  w = uw(ASEL_CELL, 1'b0, ACT_NOP,    C_OBJ_BAD,   1'b0, 1'b0, UA_LS_END);
      UA_LS_SCAN: w = uw(ASEL_COL,  1'b1, ACT_LIST,   C_LIST_STOP, 1'b1, 1'b0, UA_LS_END);
      UA_LS_END:  w = uw(ASEL_CELL, 1'b0, ACT_LEND,   C_NONE,      1'b0, 1'b1, UA_CELL_RD);
      default:    w = uw(ASEL_CELL, 1'b0, ACT_EMIT,   C_NONE,      1'b0, 1'b1, UA_CELL_RD);
    endcase
    return w;
  endfunction

  // first step of each opcode
  function automatic upc_t entry(input logic [OP_W-1:0] op);
    upc_t a;
    unique case (op)
      OP_LOAD, OP_ADD, OP_DEL: a = UA_CELL_RD;
      OP_REG:                  a = UA_REG;
      OP_DSUB:                 a = UA_DS_CHK;
      OP_LIST:                 a = UA_LS_CHK;
      default:                 a = UA_EMIT;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/access_rights_matrix_unit.sv -----
// Subject-by-object rights matrix run by a small microprogram. A request is taken when start
// is high and busy is low; busy stays high until the request's last result has been issued.
// Results appear on res_o for one cycle with res_valid_o and cannot be held off, so the
// receiver must take them as they come. Load, add right and delete right read the cell, update it
// and issue the result. Register scans the rows in order up to the configured subject count for
// the first free subject; delete subject clears its row up to the configured object count, or is
// refused for an inactive subject; list users scans the object's column, or ends at once for an
// object out of range, giving up to one result per cycle during its scan. The scans are set by
// the one read port of the cell memories, one row or column entry per cycle. After reset the block
// clears all 2**(clog2(MAX_SUBJECTS)+clog2(MAX_OBJECTS)) entries of its cell memories (256 at the
// default size), one entry per cycle, with busy high; configuration writes are taken then.
module access_rights_matrix_unit #(
  parameter int unsigned MAX_SUBJECTS = 16,
  parameter int unsigned MAX_OBJECTS  = 16,
  parameter int unsigned RIGHT_BITS   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  arm_pkg::arm_req_t          req_i,
  input  logic                       cfg_we_i,
  input  logic [arm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [arm_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                       res_valid_o,
  output arm_pkg::arm_res_t          res_o
);
  import arm_pkg::*;

  localparam int unsigned SUBJ_AW = $clog2(MAX_SUBJECTS);
  localparam int unsigned OBJ_AW  = $clog2(MAX_OBJECTS);
  localparam int unsigned MEM_AW  = SUBJ_AW + OBJ_AW;
  localparam int unsigned MEM_D   = 2 ** MEM_AW;
  localparam int unsigned CELLS   = MAX_SUBJECTS * MAX_OBJECTS;
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned MAX_DIM = (MAX_SUBJECTS > MAX_OBJECTS) ? MAX_SUBJECTS : MAX_OBJECTS;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned IDXP_W  = IDX_W + 1;

  // configuration registers
  logic [CFG_W-1:0] cfg_subj_q, cfg_obj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_subj_q <= CFG_RESET;
      cfg_obj_q  <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUBJECTS: cfg_subj_q <= cfg_data_i;
        CFG_OBJECTS:  cfg_obj_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective scan bounds
  logic [IDX_W-1:0] sbound, obound;
  assign sbound = IDX_W'((32'(cfg_subj_q) < MAX_SUBJECTS) ? 32'(cfg_subj_q) : MAX_SUBJECTS);
  assign obound = IDX_W'((32'(cfg_obj_q) < MAX_OBJECTS) ? 32'(cfg_obj_q) : MAX_OBJECTS);

  // sequencer and datapath registers
  logic                  init_q, init_d;
  logic [MEM_AW-1:0]     init_addr_q, init_addr_d;
  logic                  run_q, run_d;
  upc_t                  upc_q, upc_d;
  arm_req_t              req_q;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic                  have_q, have_d;
  logic [ID_W-1:0]       pend_id_q, pend_id_d;
  logic [RES_CW-1:0]     res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [MAX_SUBJECTS-1:0] active_q, active_d;
  logic                  pend_q;
  logic [MEM_AW-1:0]     rd_addr_q;
  logic [RIGHT_BITS-1:0] cur_rd_q, org_rd_q;
  logic                  res_valid_q, res_valid_d;
  arm_res_t              res_q, res_d;

  // cell memories
  logic [RIGHT_BITS-1:0] cur_mem [MEM_D];
  logic [RIGHT_BITS-1:0] org_mem [MEM_D];

  uword_t                uw_c;
  logic                  accept;
  logic [SUBJ_AW-1:0]    subj_idx;
  logic [OBJ_AW-1:0]     obj_idx;
  logic                  sok, ook, rok, cell_ok, act_s;
  logic [RIGHT_BITS-1:0] mask, bitm, new_val;
  logic                  old_nz, org_bit;
  logic [MEM_AW-1:0]     rd_addr, wr_addr;
  logic                  rd_ok, rd_fire;
  logic                  cur_we, org_we;
  logic [RIGHT_BITS-1:0] cur_wd, org_wd;
  logic                  reg_hit, reg_last;
  logic [SUBJ_AW-1:0]    prev_subj;
  logic                  list_hit, list_stop;
  logic                  cond_true;
  logic                  cnt_inc, cnt_dec;

  assign accept = start && !busy;
  assign busy   = init_q || run_q;
  assign uw_c   = ucode(upc_q);

  // request decode
  assign subj_idx = SUBJ_AW'(req_q.subject);
  assign obj_idx  = OBJ_AW'(req_q.object);
  assign sok      = 32'(req_q.subject) < MAX_SUBJECTS;
  assign ook      = 32'(req_q.object) < MAX_OBJECTS;
  assign rok      = 32'(req_q.right_index) < RIGHT_BITS;
  assign cell_ok  = sok && ook;
  assign act_s    = sok && active_q[subj_idx];
  assign mask     = RIGHT_BITS'(req_q.rights_mask);
  assign bitm     = RIGHT_BITS'(1) << req_q.right_index;
  assign old_nz   = |cur_rd_q;
  assign org_bit  = |(org_rd_q & bitm);

  // read address select
  always_comb begin
    rd_addr = {subj_idx, obj_idx};
    rd_ok   = 1'b1;
    unique case (uw_c.asel)
      ASEL_CELL: begin
        rd_addr = {subj_idx, obj_idx};
        rd_ok   = 1'b1;
      end
      ASEL_ROW: begin
        rd_addr = {subj_idx, OBJ_AW'(idx_q)};
        rd_ok   = idx_q < obound;
      end
      ASEL_COL: begin
        rd_addr = {SUBJ_AW'(idx_q), obj_idx};
        rd_ok   = 32'(idx_q) < MAX_SUBJECTS;
      end
      default: ;
    endcase
  end
  assign rd_fire = run_q && uw_c.rd && rd_ok;

  // scan tests
  assign reg_hit   = (idx_q < sbound) && !active_q[SUBJ_AW'(idx_q)];
  assign reg_last  = (IDXP_W'(idx_q) + IDXP_W'(1)) >= IDXP_W'(sbound);
  assign prev_subj = rd_addr_q[MEM_AW-1:OBJ_AW];
  assign list_hit  = pend_q && active_q[prev_subj] && old_nz;
  assign list_stop = (32'(idx_q) >= MAX_SUBJECTS) ||
                     (list_hit && (res_cnt_q == RES_CW'(MAX_RESULTS - 1)));

  // jump condition
  always_comb begin
    unique case (uw_c.cond)
      C_NONE:      cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_REG_STOP:  cond_true = reg_hit || reg_last;
      C_DS_REFUSE: cond_true = !act_s;
      C_ROW_DONE:  cond_true = idx_q >= obound;
      C_OBJ_BAD:   cond_true = !ook;
      C_LIST_STOP: cond_true = list_stop;
      default:     cond_true = 1'b0;
    endcase
  end

  // datapath actions
  always_comb begin
    run_d       = run_q;
    upc_d       = upc_q;
    idx_d       = idx_q;
    status_d    = status_q;
    id_d        = id_q;
    have_d      = have_q;
    pend_id_d   = pend_id_q;
    res_cnt_d   = res_cnt_q;
    active_d    = active_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    new_val     = cur_rd_q;
    cur_we      = 1'b0;
    org_we      = 1'b0;

    if (accept) begin
      run_d     = 1'b1;
      upc_d     = entry(req_i.opcode);
      idx_d     = '0;
      status_d  = ST_REFUSED;
      id_d      = '0;
      have_d    = 1'b0;
      res_cnt_d = '0;
    end else if (run_q) begin
      unique case (uw_c.act)
        ACT_NOP: ;
        ACT_CELL: begin
          unique case (req_q.opcode)
            OP_LOAD: begin
              if (cell_ok) begin
                new_val            = mask;
                cur_we             = 1'b1;
                org_we             = 1'b1;
                active_d[subj_idx] = 1'b1;
                status_d           = ST_DONE;
              end
            end
            OP_ADD: begin
              if (cell_ok && rok && act_s && org_bit) begin
                new_val  = cur_rd_q | bitm;
                cur_we   = 1'b1;
                status_d = ST_DONE;
              end
            end
            OP_DEL: begin
              if (cell_ok && rok && act_s && old_nz) begin
                new_val  = cur_rd_q & ~bitm;
                cur_we   = 1'b1;
                status_d = ST_DONE;
              end
            end
            default: ;
          endcase
        end
        ACT_EMIT: begin
          res_valid_d       = 1'b1;
          res_d.status      = status_q;
          res_d.subject_id  = id_q;
          res_d.last        = 1'b1;
          res_d.entry_count = ENTRY_W'(count_q);
        end
        ACT_REG: begin
          if (reg_hit) begin
            active_d[SUBJ_AW'(idx_q)] = 1'b1;
            status_d                  = ST_DONE;
            id_d                      = ID_W'(idx_q);
          end
        end
        ACT_CLR: begin
          if (pend_q) begin
            new_val = '0;
            cur_we  = 1'b1;
          end
        end
        ACT_DSDONE: begin
          active_d[subj_idx] = 1'b0;
          status_d           = ST_DONE;
        end
        ACT_LIST: begin
          if (list_hit) begin
            // previous hit is not the last one: send it now
            if (have_q) begin
              res_valid_d       = 1'b1;
              res_d.status      = ST_DONE;
              res_d.subject_id  = pend_id_q;
              res_d.last        = 1'b0;
              res_d.entry_count = ENTRY_W'(count_q);
            end
            have_d    = 1'b1;
            pend_id_d = ID_W'(prev_subj);
            res_cnt_d = res_cnt_q + RES_CW'(1);
          end
        end
        ACT_LEND: begin
          res_valid_d       = 1'b1;
          res_d.status      = have_q ? ST_DONE : ST_NONE;
          res_d.subject_id  = have_q ? pend_id_q : '0;
          res_d.last        = 1'b1;
          res_d.entry_count = ENTRY_W'(count_q);
        end
        default: ;
      endcase

      // step counter and jumps
      if (uw_c.hold) begin
        idx_d = idx_q + IDX_W'(1);
      end
      if (uw_c.fin) begin
        run_d = 1'b0;
      end else if (cond_true) begin
        upc_d = uw_c.jmp;
      end else if (!uw_c.hold) begin
        upc_d = upc_q + upc_t'(1);
      end
    end
  end

  // occupied cell count follows every write of the current matrix
  assign cnt_inc = run_q && cur_we && (|new_val);
  assign cnt_dec = run_q && cur_we && old_nz;
  always_comb begin
    count_d = count_q;
    if (cnt_inc && !cnt_dec) begin
      count_d = count_q + CNT_W'(1);
    end else if (cnt_dec && !cnt_inc) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // clearing pass after reset
  always_comb begin
    init_d      = init_q;
    init_addr_d = init_addr_q + MEM_AW'(1);
    if (init_q && (init_addr_q == {MEM_AW{1'b1}})) begin
      init_d = 1'b0;
    end
  end

  // memory write port
  assign wr_addr = init_q ? init_addr_q : rd_addr_q;
  assign cur_wd  = init_q ? '0 : new_val;
  assign org_wd  = init_q ? '0 : mask;

  always_ff @(posedge clk_i) begin
    if (init_q || cur_we) begin
      cur_mem[wr_addr] <= cur_wd;
    end
    if (init_q || org_we) begin
      org_mem[wr_addr] <= org_wd;
    end
    cur_rd_q <= cur_mem[rd_addr];
    org_rd_q <= org_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= 1'b1;
      init_addr_q <= '0;
      run_q       <= 1'b0;
      upc_q       <= UA_CELL_RD;
      idx_q       <= '0;
      have_q      <= 1'b0;
      res_cnt_q   <= '0;
      count_q     <= '0;
      active_q    <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      init_q      <= init_d;
      init_addr_q <= init_q ? init_addr_d : init_addr_q;
      run_q       <= run_d;
      upc_q       <= upc_d;
      idx_q       <= idx_d;
      have_q      <= have_d;
      res_cnt_q   <= res_cnt_d;
      count_q     <= count_d;
      active_q    <= active_d;
      pend_q      <= rd_fire;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rd_addr_q <= rd_addr;
    status_q  <= status_d;
    id_q      <= id_d;
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CELLS)
    else $error("occupied cell count beyond matrix size");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(run_q))
    else $error("result issued outside a running request");

  a_mem_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_we |-> run_q && !init_q)
    else $error("matrix written while idle or clearing");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == ST_NONE)) |-> res_q.last)
    else $error("nothing-found result not marked last");

endmodule
